>>> rtl/edgp_pkg.sv
`timescale 1ns / 1ps

package edgp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MOVE
  } state_t;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  localparam logic [5:0] START_RESET = 6'd31;

  // keypad direction codes
  localparam logic [3:0] DIR_DOWN_LEFT  = 4'd1;
  localparam logic [3:0] DIR_DOWN       = 4'd2;
  localparam logic [3:0] DIR_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] DIR_LEFT       = 4'd4;
  localparam logic [3:0] DIR_RIGHT      = 4'd6;
  localparam logic [3:0] DIR_UP_LEFT    = 4'd7;
  localparam logic [3:0] DIR_UP         = 4'd8;
  localparam logic [3:0] DIR_UP_RIGHT   = 4'd9;

  typedef struct packed {
    logic valid;
    logic x_dec;
    logic x_inc;
    logic y_dec;
    logic y_inc;
  } dir_t;

  // pen home update from the register port
  typedef struct packed {
    logic       set_x;
    logic       set_y;
    logic [5:0] value;
  } pen_cfg_t;

  function automatic dir_t decode_dir(input logic [3:0] code);
    dir_t d;
    d = '0;
    case (code)
      DIR_UP:         begin d.valid = 1'b1; d.y_dec = 1'b1; end
      DIR_DOWN:       begin d.valid = 1'b1; d.y_inc = 1'b1; end
      DIR_RIGHT:      begin d.valid = 1'b1; d.x_inc = 1'b1; end
      DIR_LEFT:       begin d.valid = 1'b1; d.x_dec = 1'b1; end
      DIR_UP_LEFT:    begin d.valid = 1'b1; d.x_dec = 1'b1; d.y_dec = 1'b1; end
      DIR_UP_RIGHT:   begin d.valid = 1'b1; d.x_inc = 1'b1; d.y_dec = 1'b1; end
      DIR_DOWN_LEFT:  begin d.valid = 1'b1; d.x_dec = 1'b1; d.y_inc = 1'b1; end
      DIR_DOWN_RIGHT: begin d.valid = 1'b1; d.x_inc = 1'b1; d.y_inc = 1'b1; end
      default:        d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/eight_direction_grid_plotter_unit.sv
`timescale 1ns / 1ps

// Eight-direction grid plotter: a pen walks a GRID_SIZE x GRID_SIZE one-bit bitmap.
// Request channel: a request is taken at a rising edge with start high and busy low.
//   kind 0 moves the pen length cells in a keypad direction, writing pen into each
//   cell; kind 1 reads row read_row.
// Result channel: done is high for exactly one cycle with row_bits, pos_x and pos_y.
//   The receiver cannot stall; each result must be taken in its done cycle.
// Timing: a move of n cells (n clipped by the grid edge) holds busy while it writes
//   them and raises done in the cycle after the last cell. A read holds busy in its
//   read state and raises done the cycle after. An unknown direction or zero length
//   gives done in the next cycle with busy never raised. The rate is set by the row
//   memory: one read-modify-write of one cell per cycle, reads pipelined one cell ahead.
// Registers (APB, pready always high): start_x at 0x0, start_y at 0x4. A write also
//   moves the pen on that axis, clamped to GRID_SIZE-1. Write only while idle.
// Reset (rst, synchronous): the bitmap reads as all clear at once (per-row valid
//   bits, no clearing pass), start registers return to 31, pen goes home.
module eight_direction_grid_plotter_unit #(
  parameter int GRID_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [3:0]  direction,
  input  logic [7:0]  length,
  input  logic        pen,
  input  logic [5:0]  read_row,
  // result
  output logic        done,
  output logic [63:0] row_bits,
  output logic [5:0]  pos_x,
  output logic [5:0]  pos_y,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import edgp_pkg::*;

  localparam int CW = $clog2(GRID_SIZE);

  logic [5:0]           start_x, start_y;
  logic                 cfg_wr;
  logic                 reg_idx;
  pen_cfg_t             pen_cfg;

  logic                 rd_en, wr_en;
  logic [CW-1:0]        rd_addr, wr_addr;
  logic [GRID_SIZE-1:0] rd_data, wr_data;

  // register decode: word index only, low address bits ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= START_RESET;
      start_y <= START_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_START_X) begin
        start_x <= pwdata[5:0];
      end else begin
        start_y <= pwdata[5:0];
      end
    end
  end

  assign prdata = (reg_idx == REG_START_Y) ? 32'(start_y) : 32'(start_x);

  // pen follows each start register write
  assign pen_cfg.set_x = cfg_wr && (reg_idx == REG_START_X);
  assign pen_cfg.set_y = cfg_wr && (reg_idx == REG_START_Y);
  assign pen_cfg.value = pwdata[5:0];

  edgp_move_ctrl #(
    .GRID_SIZE(GRID_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .direction (direction),
    .length    (length),
    .pen       (pen),
    .read_row  (read_row),
    .busy      (busy),
    .cfg       (pen_cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .done      (done),
    .row_bits  (row_bits),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
  );

  // bitmap: one row per entry, bit n is column n
  edgp_row_ram #(
    .GRID_SIZE(GRID_SIZE)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> rtl/edgp_row_ram.sv
`timescale 1ns / 1ps

module edgp_row_ram #(
  parameter int GRID_SIZE = 64,
  localparam int CW = $clog2(GRID_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CW-1:0]        wr_addr,
  input  logic [GRID_SIZE-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [CW-1:0]        rd_addr,
  output logic [GRID_SIZE-1:0] rd_data
);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  // rows never written since reset read as zero
  logic [GRID_SIZE-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

>>> rtl/edgp_move_ctrl.sv
`timescale 1ns / 1ps

module edgp_move_ctrl #(
  parameter int GRID_SIZE = 64,
  localparam int CW = $clog2(GRID_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 kind,
  input  logic [3:0]           direction,
  input  logic [7:0]           length,
  input  logic                 pen,
  input  logic [5:0]           read_row,
  output logic                 busy,
  input  edgp_pkg::pen_cfg_t   cfg,
  output logic                 rd_en,
  output logic [CW-1:0]        rd_addr,
  input  logic [GRID_SIZE-1:0] rd_data,
  output logic                 wr_en,
  output logic [CW-1:0]        wr_addr,
  output logic [GRID_SIZE-1:0] wr_data,
  output logic                 done,
  output logic [63:0]          row_bits,
  output logic [5:0]           pos_x,
  output logic [5:0]           pos_y
);

  import edgp_pkg::*;

  localparam logic [CW-1:0] LAST   = CW'(GRID_SIZE - 1);
  localparam logic [5:0]    LAST6  = 6'(GRID_SIZE - 1);
  localparam logic [5:0]    HOME6  = (START_RESET > LAST6) ? LAST6 : START_RESET;
  localparam logic [CW-1:0] HOME   = HOME6[CW-1:0];
  localparam logic [6:0]    ROWS7  = 7'(GRID_SIZE);

  state_t state, state_next;

  logic [CW-1:0]        pen_x, pen_y;
  logic [7:0]           cnt;
  logic                 pen_q;
  dir_t                 dir_q;
  logic                 read_ok;
  logic                 fwd_valid;
  logic [CW-1:0]        fwd_addr;
  logic [GRID_SIZE-1:0] fwd_data;

  logic                 accept, go_move, go_read, noop;
  dir_t                 dir_in;
  logic                 ok_x, ok_y, step_ok, move_more;
  logic [CW-1:0]        nx, ny;
  logic [GRID_SIZE-1:0] cur_row, cell_mask;
  logic [5:0]           cfg_cell;

  assign accept  = start && (state == ST_IDLE);
  assign dir_in  = decode_dir(direction);
  assign go_move = accept && (kind == KIND_MOVE) && dir_in.valid && (length != 8'd0);
  assign go_read = accept && (kind == KIND_READ);
  assign noop    = accept && !go_move && !go_read;

  // one step along each axis, blocked at the grid edge
  assign ok_x = !(dir_q.x_dec && pen_x == '0) && !(dir_q.x_inc && pen_x == LAST);
  assign ok_y = !(dir_q.y_dec && pen_y == '0) && !(dir_q.y_inc && pen_y == LAST);
  assign nx   = dir_q.x_dec ? pen_x - 1'b1 : (dir_q.x_inc ? pen_x + 1'b1 : pen_x);
  assign ny   = dir_q.y_dec ? pen_y - 1'b1 : (dir_q.y_inc ? pen_y + 1'b1 : pen_y);
  assign step_ok   = ok_x && ok_y;
  assign move_more = step_ok && (cnt != 8'd1);

  // a horizontal run rereads the row written in the cycle before
  assign cur_row   = (fwd_valid && fwd_addr == pen_y) ? fwd_data : rd_data;
  assign cell_mask = GRID_SIZE'(1) << pen_x;
  assign wr_data   = pen_q ? (cur_row | cell_mask) : (cur_row & ~cell_mask);
  assign wr_addr   = pen_y;

  assign cfg_cell = (cfg.value > LAST6) ? LAST6 : cfg.value;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go_move) begin
          state_next = ST_MOVE;
        end else if (go_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_MOVE: state_next = move_more ? ST_MOVE : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    rd_addr = pen_y;
    wr_en   = 1'b0;
    case (state)
      ST_IDLE: begin
        busy    = 1'b0;
        rd_en   = go_move || go_read;
        rd_addr = go_read ? read_row[CW-1:0] : pen_y;
      end
      ST_READ: busy = 1'b1;
      ST_MOVE: begin
        wr_en   = 1'b1;
        rd_en   = move_more;
        rd_addr = ny;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      fwd_valid <= 1'b0;
      pen_x     <= HOME;
      pen_y     <= HOME;
    end else begin
      state     <= state_next;
      done      <= noop || (state == ST_READ) || ((state == ST_MOVE) && !move_more);
      fwd_valid <= wr_en;
      if (cfg.set_x) begin
        pen_x <= cfg_cell[CW-1:0];
      end
      if (cfg.set_y) begin
        pen_y <= cfg_cell[CW-1:0];
      end
      if (state == ST_MOVE) begin
        if (step_ok) begin
          pen_x <= nx;
          pen_y <= ny;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= pen_y;
    fwd_data <= wr_data;
    if (accept) begin
      pen_q   <= pen;
      dir_q   <= dir_in;
      cnt     <= length;
      read_ok <= {1'b0, read_row} < ROWS7;
    end
    if (noop) begin
      row_bits <= '0;
      pos_x    <= 6'(pen_x);
      pos_y    <= 6'(pen_y);
    end
    if (state == ST_READ) begin
      row_bits <= read_ok ? 64'(rd_data) : '0;
      pos_x    <= 6'(pen_x);
      pos_y    <= 6'(pen_y);
    end
    if (state == ST_MOVE) begin
      cnt      <= cnt - 8'd1;
      row_bits <= '0;
      pos_x    <= step_ok ? 6'(nx) : 6'(pen_x);
      pos_y    <= step_ok ? 6'(ny) : 6'(pen_y);
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import edgp_pkg::*;

  // direction codes the keypad decoder does not know
  localparam logic [3:0] DIR_NONE    = 4'd0;
  localparam logic [3:0] DIR_CENTER  = 4'd5;
  localparam logic [3:0] DIR_BAD_LO  = 4'd10;
  localparam logic [3:0] DIR_BAD_HI  = 4'd15;

  localparam logic [5:0] LAST_CELL   = 6'd63;
  localparam int         QUIET_LIMIT = 4000;  // well above the longest move and the longest request gap
  localparam int         PHASES      = 10;
  localparam int         PHASE_CMDS  = 165;

  typedef struct {
    logic       kind;
    logic [3:0] dir;
    logic [7:0] len;
    logic       pen;
    logic [5:0] row;
  } plot_cmd_t;

  typedef struct {
    logic [63:0] bits;
    logic [5:0]  x;
    logic [5:0]  y;
  } pen_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = KIND_MOVE;
  logic [3:0]  direction = DIR_NONE;
  logic [7:0]  length = 8'd0;
  logic        pen = 1'b0;
  logic [5:0]  read_row = 6'd0;
  logic        done;
  logic [63:0] row_bits;
  logic [5:0]  pos_x;
  logic [5:0]  pos_y;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  eight_direction_grid_plotter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .direction(direction),
    .length   (length),
    .pen      (pen),
    .read_row (read_row),
    .done     (done),
    .row_bits (row_bits),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow plotter state: bitmap, pen cell and the two home registers.
  // ---------------------------------------------------------------------------
  logic [63:0] grid [64];
  logic [5:0]  pen_x  = START_RESET;
  logic [5:0]  pen_y  = START_RESET;
  logic [5:0]  home_x = START_RESET;
  logic [5:0]  home_y = START_RESET;

  plot_cmd_t   cmd_backlog [$];   // requests not yet offered
  pen_report_t due_reports [$];   // predicted results, oldest first

  int fails       = 0;
  int cmds_taken  = 0;
  int reads_taken = 0;
  int clipped     = 0;            // moves cut short by the grid edge
  int homes_set   = 0;
  int reports_ok  = 0;

  // Walks the pen for one request and returns what the block should report.
  // Cell is written first, then the step; a step off the grid ends the move,
  // on either axis, so diagonals stop dead instead of sliding along the edge.
  function automatic pen_report_t apply_cmd(input plot_cmd_t c);
    pen_report_t r;
    logic        known;
    logic        x_dec, x_inc, y_dec, y_inc;
    logic        going;
    int          k;
    r.bits = '0;
    known  = 1'b1;
    {x_dec, x_inc, y_dec, y_inc} = 4'b0000;
    if (c.kind == KIND_READ) begin
      r.bits = grid[c.row];
    end else begin
      case (c.dir)
        DIR_UP:         {x_dec, x_inc, y_dec, y_inc} = 4'b0010;
        DIR_DOWN:       {x_dec, x_inc, y_dec, y_inc} = 4'b0001;
        DIR_RIGHT:      {x_dec, x_inc, y_dec, y_inc} = 4'b0100;
        DIR_LEFT:       {x_dec, x_inc, y_dec, y_inc} = 4'b1000;
        DIR_UP_LEFT:    {x_dec, x_inc, y_dec, y_inc} = 4'b1010;
        DIR_UP_RIGHT:   {x_dec, x_inc, y_dec, y_inc} = 4'b0110;
        DIR_DOWN_LEFT:  {x_dec, x_inc, y_dec, y_inc} = 4'b1001;
        DIR_DOWN_RIGHT: {x_dec, x_inc, y_dec, y_inc} = 4'b0101;
        default:        known = 1'b0;
      endcase
      if (known) begin
        k = 0;
        going = 1'b1;
        while (going && k < int'(c.len)) begin
          grid[pen_y][pen_x] = c.pen;
          k++;
          if ((x_dec && pen_x == 6'd0) || (x_inc && pen_x == LAST_CELL) ||
              (y_dec && pen_y == 6'd0) || (y_inc && pen_y == LAST_CELL)) begin
            going = 1'b0;
            if (k < int'(c.len)) clipped++;
          end else begin
            if (x_dec) pen_x = pen_x - 6'd1;
            if (x_inc) pen_x = pen_x + 6'd1;
            if (y_dec) pen_y = pen_y - 6'd1;
            if (y_inc) pen_y = pen_y + 6'd1;
          end
        end
      end
    end
    r.x = pen_x;
    r.y = pen_y;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. A request is taken when start is high and busy is low.
  // With no gap, start stays high into the next request, so the next one
  // waits on busy for the whole move.
  // ---------------------------------------------------------------------------
  int        gap_left = 0;
  logic      burst = 1'b0;          // stretch of back-to-back requests
  logic      fire;
  plot_cmd_t taken;
  plot_cmd_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        taken.kind = kind;
        taken.dir  = direction;
        taken.len  = length;
        taken.pen  = pen;
        taken.row  = read_row;
        due_reports.push_back(apply_cmd(taken));
        cmds_taken++;
        if (kind == KIND_READ) reads_taken++;
        if ($urandom_range(0, 59) == 0) burst = !burst;
        if (burst) gap_left = 0;
        else if ($urandom_range(0, 99) < 60) gap_left = 0;
        else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(10, 40);
      end
      if (fire || !start) begin
        if (gap_left == 0 && cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          start     <= 1'b1;
          kind      <= nxt.kind;
          direction <= nxt.dir;
          length    <= nxt.len;
          pen       <= nxt.pen;
          read_row  <= nxt.row;
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left = gap_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: done is a one-cycle strobe, compared against the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  pen_report_t due;
  logic        clean;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_reports.size() == 0) begin
        $error("result with no request outstanding: row_bits %h pos %0d,%0d",
               row_bits, pos_x, pos_y);
        fails++;
      end else begin
        due = due_reports.pop_front();
        clean = 1'b1;
        if (row_bits !== due.bits) begin
          $error("row_bits: expected %h, got %h", due.bits, row_bits);
          clean = 1'b0;
        end
        if (pos_x !== due.x) begin
          $error("pos_x: expected %0d, got %0d", due.x, pos_x);
          clean = 1'b0;
        end
        if (pos_y !== due.y) begin
          $error("pos_y: expected %0d, got %0d", due.y, pos_y);
          clean = 1'b0;
        end
        if (clean) reports_ok++;
        else fails++;
      end
    end
  end

  // watchdog: cycles with no request, result or register access
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d results outstanding",
               quiet, due_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register port helpers
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_home(input logic idx);
    logic [31:0] rd;
    logic [5:0]  want;
    want = (idx == REG_START_X) ? home_x : home_y;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== {26'd0, want}) begin
      $error("%s: expected %0d, got %0d", (idx == REG_START_X) ? "start_x" : "start_y",
             want, rd);
      fails++;
    end
  endtask

  // writing a home register also puts the pen there on that axis
  task automatic set_home(input logic idx, input logic [5:0] home_cell);
    logic [31:0] wd;
    logic [31:0] rd;
    wd = $urandom();        // upper bits are don't-care on the write
    wd[5:0] = home_cell;
    apb_xfer(1'b1, idx, wd, rd);
    if (idx == REG_START_X) begin
      home_x = home_cell;
      pen_x  = home_cell;
    end else begin
      home_y = home_cell;
      pen_y  = home_cell;
    end
    homes_set++;
    check_home(idx);
  endtask

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  task automatic add_move(input logic [3:0] dir, input logic [7:0] len, input logic p);
    plot_cmd_t c;
    c.kind = KIND_MOVE;
    c.dir  = dir;
    c.len  = len;
    c.pen  = p;
    c.row  = 6'($urandom());
    cmd_backlog.push_back(c);
  endtask

  // pen fields carry junk on reads; the block must ignore them
  task automatic add_read(input logic [5:0] row);
    plot_cmd_t c;
    c.kind = KIND_READ;
    c.dir  = 4'($urandom());
    c.len  = 8'($urandom());
    c.pen  = 1'($urandom());
    c.row  = row;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [3:0] any_heading();
    case ($urandom_range(0, 7))
      0:       return DIR_UP;
      1:       return DIR_DOWN;
      2:       return DIR_LEFT;
      3:       return DIR_RIGHT;
      4:       return DIR_UP_LEFT;
      5:       return DIR_UP_RIGHT;
      6:       return DIR_DOWN_LEFT;
      default: return DIR_DOWN_RIGHT;
    endcase
  endfunction

  // mostly short strokes so the pen roams; some long ones to hit the edges
  task automatic add_random_cmd();
    logic [3:0] dir;
    logic [7:0] len;
    int         pick;
    if ($urandom_range(0, 99) < 30) begin
      add_read(6'($urandom()));
    end else begin
      dir  = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : any_heading();
      pick = $urandom_range(0, 99);
      if (pick < 60) len = 8'($urandom_range(0, 8));
      else if (pick < 85) len = 8'($urandom_range(0, 40));
      else len = 8'($urandom());
      add_move(dir, len, $urandom_range(0, 99) < 65);
    end
  endtask

  // idle point: nothing queued, nothing in flight
  task automatic drain();
    do @(negedge clk); while (cmd_backlog.size() != 0 || start || due_reports.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          p;
    int          n;
    logic [5:0]  hx;
    logic [5:0]  hy;
    for (int r = 0; r < 64; r++) grid[r] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // home registers come out of reset at 31
    check_home(REG_START_X);
    check_home(REG_START_Y);

    // directed: pen starts at 31,31
    add_read(6'd31);                      // empty bitmap, junk pen fields
    add_move(DIR_NONE, 8'd5, 1'b1);       // unknown codes do nothing
    add_move(DIR_CENTER, 8'd255, 1'b1);
    add_move(DIR_BAD_LO, 8'd3, 1'b0);
    add_move(DIR_BAD_HI, 8'd1, 1'b1);
    add_move(DIR_RIGHT, 8'd0, 1'b1);      // zero length: no write, no step
    add_move(DIR_RIGHT, 8'd1, 1'b1);
    add_move(DIR_UP, 8'd255, 1'b1);       // runs into the top edge
    add_move(DIR_UP_LEFT, 8'd255, 1'b1);  // already on the edge: no slide
    add_move(DIR_LEFT, 8'd255, 1'b1);     // to column 0
    add_move(DIR_DOWN, 8'd255, 1'b1);     // to row 63
    add_move(DIR_DOWN_RIGHT, 8'd255, 1'b1);
    add_move(DIR_RIGHT, 8'd255, 1'b1);    // to column 63
    add_move(DIR_UP_RIGHT, 8'd3, 1'b1);
    add_read(6'd0);
    add_read(6'd63);
    add_move(DIR_UP, 8'd10, 1'b1);
    add_move(DIR_DOWN_LEFT, 8'd20, 1'b1);
    add_move(DIR_UP_LEFT, 8'd5, 1'b1);
    add_move(DIR_UP_RIGHT, 8'd128, 1'b1); // diagonal clipped by the right edge
    add_read(6'd31);
    add_move(DIR_DOWN, 8'd255, 1'b0);     // eraser down to the bottom
    add_move(DIR_LEFT, 8'd255, 1'b0);     // clear all of row 63
    add_read(6'd63);
    add_read(6'd0);
    drain();

    // random phases, each with its own pen home; extremes first
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin hx = 6'd0;      hy = 6'd0;      end
        1:       begin hx = LAST_CELL; hy = LAST_CELL; end
        2:       begin hx = 6'd0;      hy = LAST_CELL; end
        3:       begin hx = LAST_CELL; hy = 6'd0;      end
        default: begin hx = 6'($urandom()); hy = 6'($urandom()); end
      endcase
      set_home(REG_START_X, hx);
      set_home(REG_START_Y, hy);
      for (n = 0; n < PHASE_CMDS; n++) add_random_cmd();
      drain();
    end

    // stray results after the last prediction would show up here
    repeat (70) @(posedge clk);

    $display("ran %0d requests (%0d row reads, %0d moves stopped at the edge)",
             cmds_taken, reads_taken, clipped);
    $display("%0d results matched, %0d home register writes", reports_ok, homes_set);
    if (fails == 0 && due_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (due_reports.size() != 0) $error("%0d results never arrived", due_reports.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
